// File: src/wsp_pkg.sv
`timescale 1ns / 1ps

package wsp_pkg;

    localparam int SegmentDepthDef = 32;
    localparam int CoordW          = 20;
    localparam int RangeW          = 21;
    localparam int CfgDataW        = 20;
    localparam int CfgIdxW         = 3;
    localparam int QueueDepth      = 2;

    // square root of a sum of two 21-bit squares: 22 result bits
    localparam int RootSteps = 22;
    localparam int RootW     = 44;
    localparam int RootTop   = 42;

    localparam logic [15:0] GapBaseRst   = 16'd100;
    localparam logic [15:0] AngleStepRst = 16'd571;
    localparam logic [11:0] GapGainRst   = 12'd384;
    localparam logic [15:0] LineErrRst   = 16'd50;
    localparam logic [5:0]  MinPtsRst    = 6'd5;
    localparam logic [15:0] WallLenRst   = 16'd350;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_GAP_BASE   = 3'd0,
        CFG_ANGLE_STEP = 3'd1,
        CFG_GAP_GAIN   = 3'd2,
        CFG_LINE_ERR   = 3'd3,
        CFG_MIN_POINTS = 3'd4,
        CFG_WALL_LEN   = 3'd5,
        CFG_POS_X      = 3'd6,
        CFG_POS_Y      = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0]              gap_base;
        logic [15:0]              angle_step;
        logic [11:0]              gap_gain;
        logic [15:0]              line_error_limit;
        logic [5:0]               min_wall_points;
        logic [15:0]              wall_length;
        logic signed [CoordW-1:0] pos_x;
        logic signed [CoordW-1:0] pos_y;
    } t_cfg;

    typedef struct packed {
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic [RangeW-1:0]        range;
        logic                     last;
    } t_pt;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SQ,
        F_SUM,
        F_ROOT,
        F_PUSH
    } t_front_state;

    typedef enum logic [4:0] {
        B_IDLE,
        B_GAP_SQ,
        B_GAP_MUL,
        B_GAP_THR,
        B_GAP_THR2,
        B_GAP_DEC,
        B_START,
        B_AFTER,
        B_WALL_SQ,
        B_WALL_SUM,
        B_WALL_DEC,
        B_PT_RD,
        B_PT_MUL,
        B_PT_ABS,
        B_PT_SQ,
        B_PT_CMP,
        B_EMIT_RD,
        B_EMIT_OUT,
        B_CLOSED,
        B_MARK
    } t_back_state;

endpackage

// File: src/wsp_if.sv
`timescale 1ns / 1ps

interface wsp_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [wsp_pkg::CoordW-1:0]   point_x;
    logic signed [wsp_pkg::CoordW-1:0]   point_y;
    logic                                scan_last;

    modport source (output valid, output point_x, output point_y, output scan_last,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input scan_last,
                  output ready);
endinterface

interface wsp_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [wsp_pkg::CoordW-1:0]   out_x;
    logic signed [wsp_pkg::CoordW-1:0]   out_y;
    logic                                end_marker;
    logic                                segment_split;
    logic                                run_last;

    modport source (output valid, output out_x, output out_y, output end_marker,
                    output segment_split, output run_last, input ready);
    modport sink (input valid, input out_x, input out_y, input end_marker,
                  input segment_split, input run_last, output ready);
endinterface

// File: src/wsp_front.sv
`timescale 1ns / 1ps

module wsp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wsp_pkg::t_cfg     i_cfg,
    wsp_in_if.sink            i_pt,
    output logic              o_q_valid,
    output wsp_pkg::t_pt      o_q_data,
    input  logic              i_q_ready
);

    localparam int StepW = $clog2(wsp_pkg::RootSteps);

    wsp_pkg::t_front_state r_state, n_state;

    logic signed [wsp_pkg::CoordW-1:0] r_x, r_y;
    logic                              r_last;
    logic [41:0]                       r_sqx, r_sqy;
    logic [wsp_pkg::RootW-1:0]         r_v, r_r, r_bit;
    logic [StepW-1:0]                  r_step;

    logic signed [20:0] dx, dy;
    logic signed [41:0] mx, my;
    logic [wsp_pkg::RootW-1:0] trial;
    logic take, root_done;

    assign take      = i_pt.valid && i_pt.ready;
    assign dx        = 21'(r_x) - 21'(i_cfg.pos_x);
    assign dy        = 21'(r_y) - 21'(i_cfg.pos_y);
    assign mx        = dx * dx;
    assign my        = dy * dy;
    assign trial     = r_r + r_bit;
    assign root_done = (r_step == StepW'(wsp_pkg::RootSteps - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            wsp_pkg::F_IDLE: if (i_pt.valid) n_state = wsp_pkg::F_SQ;
            wsp_pkg::F_SQ:   n_state = wsp_pkg::F_SUM;
            wsp_pkg::F_SUM:  n_state = wsp_pkg::F_ROOT;
            wsp_pkg::F_ROOT: if (root_done) n_state = wsp_pkg::F_PUSH;
            wsp_pkg::F_PUSH: if (i_q_ready) n_state = wsp_pkg::F_IDLE;
            default:         n_state = wsp_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        i_pt.ready     = (r_state == wsp_pkg::F_IDLE);
        o_q_valid      = (r_state == wsp_pkg::F_PUSH);
        o_q_data.x     = r_x;
        o_q_data.y     = r_y;
        o_q_data.range = r_r[wsp_pkg::RangeW-1:0];
        o_q_data.last  = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wsp_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_x    <= i_pt.point_x;
            r_y    <= i_pt.point_y;
            r_last <= i_pt.scan_last;
        end
        case (r_state)
            wsp_pkg::F_SQ: begin
                r_sqx <= 42'(mx);
                r_sqy <= 42'(my);
            end
            wsp_pkg::F_SUM: begin
                r_v    <= wsp_pkg::RootW'(r_sqx) + wsp_pkg::RootW'(r_sqy);
                r_r    <= '0;
                r_bit  <= wsp_pkg::RootW'(1) << wsp_pkg::RootTop;
                r_step <= '0;
            end
            wsp_pkg::F_ROOT: begin
                if (r_v >= trial) begin
                    r_v <= r_v - trial;
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit  <= r_bit >> 2;
                r_step <= r_step + StepW'(1);
            end
            default: begin
            end
        endcase
    end

endmodule

// File: src/wsp_queue.sv
`timescale 1ns / 1ps

module wsp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  wsp_pkg::t_pt  i_data,
    output logic          o_ready,
    output logic          o_valid,
    output wsp_pkg::t_pt  o_data,
    input  logic          i_ready
);

    localparam int PtrW = $clog2(wsp_pkg::QueueDepth);
    localparam int CntW = $clog2(wsp_pkg::QueueDepth + 1);

    wsp_pkg::t_pt    r_buf [wsp_pkg::QueueDepth];
    logic [PtrW-1:0] r_wp, r_rp;
    logic [CntW-1:0] r_cnt;
    logic            push, pop;

    assign o_ready = (r_cnt != CntW'(wsp_pkg::QueueDepth));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_buf[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + PtrW'(1);
            if (pop)  r_rp <= r_rp + PtrW'(1);
            if (push && !pop) r_cnt <= r_cnt + CntW'(1);
            else if (pop && !push) r_cnt <= r_cnt - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_buf[r_wp] <= i_data;
    end

endmodule

// File: src/wsp_back.sv
`timescale 1ns / 1ps

module wsp_back #(
    parameter int DEPTH = wsp_pkg::SegmentDepthDef
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  wsp_pkg::t_cfg i_cfg,
    input  logic          i_q_valid,
    input  wsp_pkg::t_pt  i_q_data,
    output logic          o_q_ready,
    wsp_out_if.source     o_res
);

    localparam int CntW = $clog2(DEPTH + 1);
    localparam int IdxW = $clog2(DEPTH);

    wsp_pkg::t_back_state r_state, n_state;

    logic signed [wsp_pkg::CoordW-1:0] r_mem_x [DEPTH];
    logic signed [wsp_pkg::CoordW-1:0] r_mem_y [DEPTH];
    logic signed [wsp_pkg::CoordW-1:0] r_mx, r_my;

    logic signed [wsp_pkg::CoordW-1:0] r_px, r_py, r_fx, r_fy, r_lx, r_ly;
    logic [wsp_pkg::RangeW-1:0]        r_rc, r_prev;
    logic                              r_last, r_split, r_forced, r_phase;
    logic [CntW-1:0]                   r_count;
    logic [IdxW-1:0]                   r_idx;

    logic [41:0] r_sqx, r_sqy;
    logic [37:0] r_p1;
    logic [42:0] r_gap2, r_chord;
    logic [49:0] r_prod;
    logic [33:0] r_thr;
    logic [57:0] r_thr2;
    logic        r_big;
    logic [31:0] r_wl2, r_lim2;
    logic [63:0] r_lh, r_a2;
    logic signed [20:0] r_ex, r_ey;
    logic signed [37:0] r_c1, r_c2;
    logic [38:0] r_a;

    logic                              r_ov, r_oend, r_osplit, r_olast;
    logic signed [wsp_pkg::CoordW-1:0] r_ox, r_oy;

    logic signed [20:0] gdx, gdy, wex, wey, dxi, dyi, sdx, sdy;
    logic signed [41:0] sqx, sqy;
    logic signed [16:0] ex17, ey17;
    logic signed [37:0] c1, c2;
    logic signed [38:0] cw;
    logic               join_ok, full, enough, pt_fail, idx_last, out_free, mem_we, ov_set;
    logic [IdxW-1:0]    waddr;

    assign gdx      = 21'(r_px) - 21'(r_lx);
    assign gdy      = 21'(r_py) - 21'(r_ly);
    assign wex      = 21'(r_lx) - 21'(r_fx);
    assign wey      = 21'(r_ly) - 21'(r_fy);
    assign sdx      = (r_state == wsp_pkg::B_GAP_SQ) ? gdx : wex;
    assign sdy      = (r_state == wsp_pkg::B_GAP_SQ) ? gdy : wey;
    assign sqx      = sdx * sdx;
    assign sqy      = sdy * sdy;
    assign ex17     = r_ex[16:0];
    assign ey17     = r_ey[16:0];
    assign dxi      = 21'(r_mx) - 21'(r_fx);
    assign dyi      = 21'(r_my) - 21'(r_fy);
    assign c1       = ey17 * dxi;
    assign c2       = ex17 * dyi;
    assign cw       = 39'(r_c1) - 39'(r_c2);
    assign full     = (r_count == CntW'(DEPTH));
    assign join_ok  = r_big || (64'({r_gap2, 16'h0000}) < 64'(r_thr2));
    assign enough   = (8'(r_count) >= 8'(i_cfg.min_wall_points));
    assign pt_fail  = r_big || !(r_a2 < r_lh);
    assign idx_last = (CntW'(r_idx) == r_count - CntW'(1));
    assign out_free = !r_ov || o_res.ready;
    assign ov_set   = out_free && (r_state == wsp_pkg::B_EMIT_OUT ||
                                   r_state == wsp_pkg::B_MARK);

    always_comb begin
        n_state = r_state;
        case (r_state)
            wsp_pkg::B_IDLE:
                if (i_q_valid) n_state = (r_count == '0) ? wsp_pkg::B_START
                                                         : wsp_pkg::B_GAP_SQ;
            wsp_pkg::B_GAP_SQ:   n_state = wsp_pkg::B_GAP_MUL;
            wsp_pkg::B_GAP_MUL:  n_state = wsp_pkg::B_GAP_THR;
            wsp_pkg::B_GAP_THR:  n_state = wsp_pkg::B_GAP_THR2;
            wsp_pkg::B_GAP_THR2: n_state = wsp_pkg::B_GAP_DEC;
            wsp_pkg::B_GAP_DEC:
                n_state = (join_ok && !full) ? wsp_pkg::B_AFTER : wsp_pkg::B_WALL_SQ;
            wsp_pkg::B_START:    n_state = wsp_pkg::B_AFTER;
            wsp_pkg::B_AFTER:    n_state = r_last ? wsp_pkg::B_WALL_SQ : wsp_pkg::B_IDLE;
            wsp_pkg::B_WALL_SQ:  n_state = wsp_pkg::B_WALL_SUM;
            wsp_pkg::B_WALL_SUM: n_state = wsp_pkg::B_WALL_DEC;
            wsp_pkg::B_WALL_DEC: begin
                if (!enough)                      n_state = wsp_pkg::B_EMIT_RD;
                else if (43'(r_wl2) < r_chord)    n_state = wsp_pkg::B_CLOSED;
                else if (r_chord == '0)           n_state = wsp_pkg::B_EMIT_RD;
                else                              n_state = wsp_pkg::B_PT_RD;
            end
            wsp_pkg::B_PT_RD:  n_state = wsp_pkg::B_PT_MUL;
            wsp_pkg::B_PT_MUL: n_state = wsp_pkg::B_PT_ABS;
            wsp_pkg::B_PT_ABS: n_state = wsp_pkg::B_PT_SQ;
            wsp_pkg::B_PT_SQ:  n_state = wsp_pkg::B_PT_CMP;
            wsp_pkg::B_PT_CMP: begin
                if (pt_fail)       n_state = wsp_pkg::B_EMIT_RD;
                else if (idx_last) n_state = wsp_pkg::B_CLOSED;
                else               n_state = wsp_pkg::B_PT_RD;
            end
            wsp_pkg::B_EMIT_RD:  n_state = wsp_pkg::B_EMIT_OUT;
            wsp_pkg::B_EMIT_OUT:
                if (out_free) n_state = idx_last ? wsp_pkg::B_CLOSED : wsp_pkg::B_EMIT_RD;
            wsp_pkg::B_CLOSED:   n_state = r_phase ? wsp_pkg::B_MARK : wsp_pkg::B_START;
            wsp_pkg::B_MARK:     if (out_free) n_state = wsp_pkg::B_IDLE;
            default:             n_state = wsp_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_q_ready           = (r_state == wsp_pkg::B_IDLE);
        mem_we              = (r_state == wsp_pkg::B_START) ||
                              (r_state == wsp_pkg::B_GAP_DEC && join_ok && !full);
        waddr               = (r_state == wsp_pkg::B_START) ? '0 : r_count[IdxW-1:0];
        o_res.valid         = r_ov;
        o_res.out_x         = r_ox;
        o_res.out_y         = r_oy;
        o_res.end_marker    = r_oend;
        o_res.segment_split = r_osplit;
        o_res.run_last      = r_olast;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_x[waddr] <= r_px;
            r_mem_y[waddr] <= r_py;
        end
        r_mx <= r_mem_x[r_idx];
        r_my <= r_mem_y[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wsp_pkg::B_IDLE;
            r_count <= '0;
            r_split <= 1'b0;
            r_prev  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ov_set) r_ov <= 1'b1;
            else if (o_res.ready) r_ov <= 1'b0;
            case (r_state)
                wsp_pkg::B_GAP_DEC:
                    if (join_ok && !full) r_count <= r_count + CntW'(1);
                wsp_pkg::B_START: begin
                    r_count <= CntW'(1);
                    r_split <= r_forced;
                end
                wsp_pkg::B_AFTER:  r_prev <= r_rc;
                wsp_pkg::B_CLOSED: r_count <= '0;
                wsp_pkg::B_MARK:
                    if (out_free) begin
                        r_count <= '0;
                        r_split <= 1'b0;
                        r_prev  <= '0;
                    end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            wsp_pkg::B_IDLE:
                if (i_q_valid) begin
                    r_px     <= i_q_data.x;
                    r_py     <= i_q_data.y;
                    r_rc     <= i_q_data.range;
                    r_last   <= i_q_data.last;
                    r_forced <= 1'b0;
                    r_phase  <= 1'b0;
                end
            wsp_pkg::B_GAP_SQ: begin
                r_sqx <= 42'(sqx);
                r_sqy <= 42'(sqy);
                r_p1  <= 38'(22'(r_prev) + 22'(r_rc)) * 38'(i_cfg.angle_step);
            end
            wsp_pkg::B_GAP_MUL: begin
                r_gap2 <= 43'(r_sqx) + 43'(r_sqy);
                r_prod <= 50'(r_p1) * 50'(i_cfg.gap_gain);
            end
            wsp_pkg::B_GAP_THR:
                r_thr <= 34'({i_cfg.gap_base, 8'h00}) + 34'(r_prod[49:17]);
            wsp_pkg::B_GAP_THR2: begin
                r_thr2 <= 58'(r_thr[28:0]) * 58'(r_thr[28:0]);
                r_big  <= |r_thr[33:29];
            end
            wsp_pkg::B_GAP_DEC: begin
                r_forced <= join_ok && full;
                r_phase  <= 1'b0;
                if (join_ok && !full) begin
                    r_lx <= r_px;
                    r_ly <= r_py;
                end
            end
            wsp_pkg::B_START: begin
                r_fx <= r_px;
                r_fy <= r_py;
                r_lx <= r_px;
                r_ly <= r_py;
            end
            wsp_pkg::B_AFTER: begin
                r_forced <= 1'b0;
                r_phase  <= 1'b1;
            end
            wsp_pkg::B_WALL_SQ: begin
                r_sqx <= 42'(sqx);
                r_sqy <= 42'(sqy);
                r_ex  <= wex;
                r_ey  <= wey;
            end
            wsp_pkg::B_WALL_SUM: begin
                r_chord <= 43'(r_sqx) + 43'(r_sqy);
                r_wl2   <= 32'(i_cfg.wall_length) * 32'(i_cfg.wall_length);
                r_lim2  <= 32'(i_cfg.line_error_limit) * 32'(i_cfg.line_error_limit);
            end
            wsp_pkg::B_WALL_DEC: begin
                r_lh  <= 64'(r_lim2) * 64'(r_chord[31:0]);
                r_idx <= '0;
            end
            wsp_pkg::B_PT_MUL: begin
                r_c1 <= c1;
                r_c2 <= c2;
            end
            wsp_pkg::B_PT_ABS:
                r_a <= cw[38] ? 39'(-cw) : 39'(cw);
            wsp_pkg::B_PT_SQ: begin
                r_big <= |r_a[38:32];
                r_a2  <= 64'(r_a[31:0]) * 64'(r_a[31:0]);
            end
            wsp_pkg::B_PT_CMP:
                r_idx <= pt_fail ? '0 : r_idx + IdxW'(1);
            wsp_pkg::B_EMIT_OUT:
                if (out_free) begin
                    r_ox     <= r_mx;
                    r_oy     <= r_my;
                    r_oend   <= 1'b0;
                    r_osplit <= r_forced | r_split;
                    r_olast  <= idx_last && !r_last;
                    r_idx    <= r_idx + IdxW'(1);
                end
            wsp_pkg::B_MARK:
                if (out_free) begin
                    r_ox     <= '0;
                    r_oy     <= '0;
                    r_oend   <= 1'b1;
                    r_osplit <= 1'b0;
                    r_olast  <= 1'b1;
                end
            default: begin
            end
        endcase
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(DEPTH))
        else $error("segment count above buffer depth");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> !full)
        else $error("segment buffer written while full");

    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_oend) |-> (r_olast && !r_osplit))
        else $error("end marker without run_last");

    a_mark_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wsp_pkg::B_MARK && out_free) |=>
        (r_count == '0 && r_prev == '0 && r_state == wsp_pkg::B_IDLE))
        else $error("scan end left state behind");
`endif

endmodule

// File: src/wall_segment_point_filter.sv
`timescale 1ns / 1ps

// Wall segment point filter. Scan points enter on i_pt; points of segments that
// are not walls leave on o_res, followed by an end marker after the point with
// scan_last set. The front computes each point's sensor range with a bit-serial
// square root (one result bit per cycle) and takes no new point until the last
// is pushed; a two-beat queue lets it work ahead of the back end. The back end
// runs the gap test on a joining point; closing a segment computes the chord,
// sweeps the segment buffer (one read port) for line error and emits the kept
// points, subject to output stalls. The user writes configuration through
// i_cfg_we / i_cfg_idx / i_cfg_data only while idle; the block does not check.
module wall_segment_point_filter #(
    parameter int SEGMENT_DEPTH = wsp_pkg::SegmentDepthDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [wsp_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [wsp_pkg::CfgDataW-1:0]  i_cfg_data,
    wsp_in_if.sink                        i_pt,
    wsp_out_if.source                     o_res
);

    wsp_pkg::t_cfg r_cfg;
    logic          q_in_valid, q_in_ready, q_out_valid, q_out_ready;
    wsp_pkg::t_pt  q_in_data, q_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gap_base         <= wsp_pkg::GapBaseRst;
            r_cfg.angle_step       <= wsp_pkg::AngleStepRst;
            r_cfg.gap_gain         <= wsp_pkg::GapGainRst;
            r_cfg.line_error_limit <= wsp_pkg::LineErrRst;
            r_cfg.min_wall_points  <= wsp_pkg::MinPtsRst;
            r_cfg.wall_length      <= wsp_pkg::WallLenRst;
            r_cfg.pos_x            <= '0;
            r_cfg.pos_y            <= '0;
        end else if (i_cfg_we) begin
            case (wsp_pkg::t_cfg_idx'(i_cfg_idx))
                wsp_pkg::CFG_GAP_BASE:   r_cfg.gap_base         <= i_cfg_data[15:0];
                wsp_pkg::CFG_ANGLE_STEP: r_cfg.angle_step       <= i_cfg_data[15:0];
                wsp_pkg::CFG_GAP_GAIN:   r_cfg.gap_gain         <= i_cfg_data[11:0];
                wsp_pkg::CFG_LINE_ERR:   r_cfg.line_error_limit <= i_cfg_data[15:0];
                wsp_pkg::CFG_MIN_POINTS: r_cfg.min_wall_points  <= i_cfg_data[5:0];
                wsp_pkg::CFG_WALL_LEN:   r_cfg.wall_length      <= i_cfg_data[15:0];
                wsp_pkg::CFG_POS_X:      r_cfg.pos_x            <= i_cfg_data;
                wsp_pkg::CFG_POS_Y:      r_cfg.pos_y            <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    wsp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_pt      (i_pt),
        .o_q_valid (q_in_valid),
        .o_q_data  (q_in_data),
        .i_q_ready (q_in_ready)
    );

    wsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_in_valid),
        .i_data  (q_in_data),
        .o_ready (q_in_ready),
        .o_valid (q_out_valid),
        .o_data  (q_out_data),
        .i_ready (q_out_ready)
    );

    wsp_back #(
        .DEPTH (SEGMENT_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_out_valid),
        .i_q_data  (q_out_data),
        .o_q_ready (q_out_ready),
        .o_res     (o_res)
    );

endmodule

// File: sim/wsp_point_checker.sv
`timescale 1ns / 1ps

module wsp_point_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [wsp_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [wsp_pkg::CfgDataW-1:0] i_cfg_data,
    wsp_in_if                            pt,
    wsp_out_if                           res,
    output int                           o_errors,
    output int                           o_pending
);

    localparam int Depth = wsp_pkg::SegmentDepthDef;

    typedef struct {
        logic signed [wsp_pkg::CoordW-1:0] x;
        logic signed [wsp_pkg::CoordW-1:0] y;
        logic                              endm;
        logic                              split;
        logic                              last;
    } t_kept;

    t_kept kept_q[$];

    longint unsigned gap_base, angle_step, gap_gain, line_err, min_pts, wall_len;
    longint          sens_x, sens_y;
    longint          seg_px[Depth];
    longint          seg_py[Depth];
    int              seg_cnt;
    bit              seg_split;
    longint unsigned prev_range;

    assign o_pending = kept_q.size();

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'h1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic bit seg_is_wall();
        longint          ex, ey, c;
        longint unsigned chord2;
        logic [127:0]    lim2, ca;
        if (seg_cnt == 0 || seg_cnt < min_pts) return 0;
        ex = seg_px[seg_cnt-1] - seg_px[0];
        ey = seg_py[seg_cnt-1] - seg_py[0];
        chord2 = ex * ex + ey * ey;
        if (chord2 > wall_len * wall_len) return 1;
        if (chord2 == 0) return 0;
        lim2 = 128'(line_err * line_err) * 128'(chord2);
        for (int i = 0; i < seg_cnt; i++) begin
            c = ey * (seg_px[i] - seg_px[0]) - ex * (seg_py[i] - seg_py[0]);
            ca = 128'(c < 0 ? -c : c);
            if (!(ca * ca < lim2)) return 0;
        end
        return 1;
    endfunction

    task automatic push_kept(longint x, longint y, bit endm, bit split);
        t_kept k;
        k.x = x[wsp_pkg::CoordW-1:0];
        k.y = y[wsp_pkg::CoordW-1:0];
        k.endm = endm;
        k.split = split;
        k.last = 0;
        kept_q.insert(kept_q.size(), k);
    endtask

    task automatic close_seg(bit forced);
        bit flag;
        flag = forced | seg_split;
        if (!seg_is_wall())
            for (int i = 0; i < seg_cnt; i++) push_kept(seg_px[i], seg_py[i], 0, flag);
        seg_cnt = 0;
    endtask

    task automatic open_seg(longint x, longint y, bit split);
        seg_px[0] = x;
        seg_py[0] = y;
        seg_cnt = 1;
        seg_split = split;
    endtask

    task automatic predict_point(longint x, longint y, bit last);
        longint          dx, dy;
        longint unsigned rc, gap2, prod, thr;
        int              first;
        bit              joins;
        first = kept_q.size();
        dx = x - sens_x;
        dy = y - sens_y;
        rc = root_floor(dx * dx + dy * dy);
        if (seg_cnt == 0) begin
            open_seg(x, y, 0);
        end else begin
            dx = x - seg_px[seg_cnt-1];
            dy = y - seg_py[seg_cnt-1];
            gap2 = dx * dx + dy * dy;
            prod = (prev_range + rc) * angle_step * gap_gain;
            thr = (gap_base << 8) + (prod >> 17);
            joins = thr >= (64'h1 << 29) || (gap2 << 16) < thr * thr;
            if (joins && seg_cnt < Depth) begin
                seg_px[seg_cnt] = x;
                seg_py[seg_cnt] = y;
                seg_cnt++;
            end else begin
                close_seg(joins);
                open_seg(x, y, joins);
            end
        end
        prev_range = rc;
        if (last) begin
            close_seg(0);
            push_kept(0, 0, 1, 0);
            seg_split = 0;
            prev_range = 0;
        end
        if (kept_q.size() > first) kept_q[$].last = 1;
    endtask

    task automatic report(string what, t_kept want);
        $display("mismatch %s: got x=%0d y=%0d e=%b s=%b l=%b want x=%0d y=%0d e=%b s=%b l=%b",
                 what, res.out_x, res.out_y, res.end_marker, res.segment_split,
                 res.run_last, want.x, want.y, want.endm, want.split, want.last);
        o_errors++;
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_kept want;
        if (!i_rst_n) begin
            gap_base   = wsp_pkg::GapBaseRst;
            angle_step = wsp_pkg::AngleStepRst;
            gap_gain   = wsp_pkg::GapGainRst;
            line_err   = wsp_pkg::LineErrRst;
            min_pts    = wsp_pkg::MinPtsRst;
            wall_len   = wsp_pkg::WallLenRst;
            sens_x     = 0;
            sens_y     = 0;
            seg_cnt    = 0;
            seg_split  = 0;
            prev_range = 0;
            kept_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (wsp_pkg::t_cfg_idx'(i_cfg_idx))
                    wsp_pkg::CFG_GAP_BASE:   gap_base   = i_cfg_data[15:0];
                    wsp_pkg::CFG_ANGLE_STEP: angle_step = i_cfg_data[15:0];
                    wsp_pkg::CFG_GAP_GAIN:   gap_gain   = i_cfg_data[11:0];
                    wsp_pkg::CFG_LINE_ERR:   line_err   = i_cfg_data[15:0];
                    wsp_pkg::CFG_MIN_POINTS: min_pts    = i_cfg_data[5:0];
                    wsp_pkg::CFG_WALL_LEN:   wall_len   = i_cfg_data[15:0];
                    wsp_pkg::CFG_POS_X:      sens_x     = longint'($signed(i_cfg_data));
                    wsp_pkg::CFG_POS_Y:      sens_y     = longint'($signed(i_cfg_data));
                    default: ;
                endcase
            end
            if (res.valid && res.ready) begin
                if (kept_q.size() == 0) begin
                    want = '{default: 0};
                    report("unexpected beat", want);
                end else begin
                    want = kept_q.pop_front();
                    if (res.out_x !== want.x || res.out_y !== want.y ||
                        res.end_marker !== want.endm || res.segment_split !== want.split ||
                        res.run_last !== want.last)
                        report("field", want);
                end
            end
            if (pt.valid && pt.ready)
                predict_point(longint'(pt.point_x), longint'(pt.point_y), pt.scan_last);
        end
    end

endmodule

// File: sim/wall_segment_point_filter_test.sv
`timescale 1ns / 1ps

module wall_segment_point_filter_test;

    localparam int IdleLimit = 20000;
    localparam int ItemGoal  = 420;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         cfg_we;
    logic [wsp_pkg::CfgIdxW-1:0]  cfg_idx;
    logic [wsp_pkg::CfgDataW-1:0] cfg_data;
    int                           errors, pending, sent, send_idle, recv_stall, quiet;

    wsp_in_if  pt_if ();
    wsp_out_if res_if ();

    wall_segment_point_filter uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pt       (pt_if.sink),
        .o_res      (res_if.source)
    );

    wsp_point_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .pt         (pt_if),
        .res        (res_if),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial i_clk = 0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= IdleLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send(int x, int y, bit last);
        while ($urandom_range(99) < send_idle) begin
            pt_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_if.valid     <= 1'b1;
        pt_if.point_x   <= x[wsp_pkg::CoordW-1:0];
        pt_if.point_y   <= y[wsp_pkg::CoordW-1:0];
        pt_if.scan_last <= last;
        do @(posedge i_clk); while (!pt_if.ready);
        sent++;
    endtask

    task automatic drain();
        pt_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_cfg(wsp_pkg::t_cfg_idx idx, int value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value[wsp_pkg::CfgDataW-1:0];
        @(posedge i_clk);
    endtask

    task automatic load_cfg(int gb, int st, int gn, int le, int mp, int wl, int sx, int sy);
        write_cfg(wsp_pkg::CFG_GAP_BASE, gb);
        write_cfg(wsp_pkg::CFG_ANGLE_STEP, st);
        write_cfg(wsp_pkg::CFG_GAP_GAIN, gn);
        write_cfg(wsp_pkg::CFG_LINE_ERR, le);
        write_cfg(wsp_pkg::CFG_MIN_POINTS, mp);
        write_cfg(wsp_pkg::CFG_WALL_LEN, wl);
        write_cfg(wsp_pkg::CFG_POS_X, sx);
        write_cfg(wsp_pkg::CFG_POS_Y, sy);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int clamp20(int v);
        if (v > 524287) return 524287;
        if (v < -524288) return -524288;
        return v;
    endfunction

    // one scan: mostly walks and straight runs, some random noise points
    task automatic send_scan(int npts);
        int x, y, sx, sy, jit;
        x   = $urandom_range(40000) - 20000;
        y   = $urandom_range(40000) - 20000;
        sx  = $urandom_range(80) - 40;
        sy  = $urandom_range(80) - 40;
        jit = $urandom_range(3) == 0 ? 0 : $urandom_range(30);
        for (int i = 0; i < npts; i++) begin
            case ($urandom_range(19))
                0: begin
                    x = $signed(20'($urandom));
                    y = $signed(20'($urandom));
                end
                1, 2: begin
                    x = clamp20(x + $urandom_range(4000) - 2000);
                    y = clamp20(y + $urandom_range(4000) - 2000);
                end
                3: begin
                    sx = $urandom_range(80) - 40;
                    sy = $urandom_range(80) - 40;
                end
                default: begin
                    x = clamp20(x + sx + $urandom_range(2 * jit) - jit);
                    y = clamp20(y + sy + $urandom_range(2 * jit) - jit);
                end
            endcase
            send(x, y, i == npts - 1);
        end
    endtask

    task automatic random_phase(int goal, bit hold);
        int start;
        start = sent;
        while (sent - start < goal) begin
            send_scan($urandom_range(7) == 0 ? $urandom_range(45, 33) : $urandom_range(20, 1));
            if (hold && sent - start > goal / 2) begin
                pt_if.valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
                hold = 0;
            end
        end
        drain();
    endtask

    initial begin
        sent = 0;
        send_idle = 0;
        recv_stall = 0;
        i_rst_n = 0;
        cfg_we = 0;
        cfg_idx = '0;
        cfg_data = '0;
        pt_if.valid = 0;
        pt_if.point_x = '0;
        pt_if.point_y = '0;
        pt_if.scan_last = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // coordinate extremes, far jump
        send(-524288, -524288, 0);
        send(524287, 524287, 0);
        send(0, 0, 1);
        // repeated point: zero chord
        for (int i = 0; i < 7; i++) send(1000, 1000, i == 6);
        // straight run: wall by length
        for (int i = 0; i < 8; i++) send(2000 + 60 * i, 3000, i == 7);
        // short noisy run below point count
        for (int i = 0; i < 4; i++) send(-3000 + 20 * i, 500 + 7 * (i % 2), i == 3);
        send(5, 5, 1);
        drain();

        random_phase(ItemGoal / 6, 1);

        send_idle = 73;
        load_cfg(65535, 65535, 4095, 0, 0, 0, -524288, 524287);
        random_phase(ItemGoal / 6, 0);

        send_idle = 0;
        recv_stall = 73;
        load_cfg(0, 0, 0, 65535, 32, 65535, 524287, -524288);
        random_phase(ItemGoal / 6, 0);

        send_idle = 31;
        recv_stall = 31;
        load_cfg(60, 900, 256, 20, 3, 500, 1500, -800);
        random_phase(ItemGoal / 6, 0);

        send_idle = 0;
        recv_stall = 0;
        load_cfg($urandom_range(300), $urandom_range(2000), $urandom_range(1024),
                 $urandom_range(100), $urandom_range(32), $urandom_range(1000),
                 $urandom_range(20000) - 10000, $urandom_range(20000) - 10000);
        random_phase(ItemGoal / 6, 1);

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
